// ===== rtl/core/apsp_pkg.sv =====
// Package: shared constants, opcodes and the sequencer microprogram.
package apsp_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_DIST_BITS = 24;
  localparam int OUT_BITS      = 24;
  localparam int CNT_BITS      = 5;
  localparam int WEIGHT_BITS   = 16;
  localparam int IDX_BITS      = 4;
  localparam logic [CNT_BITS-1:0] NODE_COUNT_RESET = 5'd16;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // microprogram step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_RD_OUT   = 4'd1;
  localparam logic [PC_W-1:0] PC_RUN_INIT = 4'd2;
  localparam logic [PC_W-1:0] PC_DIAG     = 4'd3;
  localparam logic [PC_W-1:0] PC_COPY_RD  = 4'd4;
  localparam logic [PC_W-1:0] PC_COPY_WR  = 4'd5;
  localparam logic [PC_W-1:0] PC_RELAX_RD = 4'd6;
  localparam logic [PC_W-1:0] PC_RELAX_WR = 4'd7;
  localparam logic [PC_W-1:0] PC_NEXT_K   = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd9;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_STEP,
    CNT_STEP_ON_J
  } cnt_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_DIAG,
    WR_RELAX
  } mem_wr_t;

  typedef enum logic [1:0] {
    RD_HOST,
    RD_COPY,
    RD_RELAX
  } mem_rd_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_READ,
    LD_ZERO
  } out_ld_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_N_ZERO,
    COND_I_MORE,
    COND_IJ_MORE,
    COND_K_MORE
  } cond_t;

  typedef struct packed {
    logic            dispatch;
    cnt_op_t         i_op;
    cnt_op_t         j_op;
    cnt_op_t         k_op;
    mem_wr_t         wr;
    mem_rd_t         rd;
    logic            piv_wr;
    out_ld_t         ld;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    dispatch: 1'b0, i_op: CNT_HOLD, j_op: CNT_HOLD, k_op: CNT_HOLD,
    wr: WR_NONE, rd: RD_HOST, piv_wr: 1'b0, ld: LD_NONE,
    cond: COND_ALWAYS, target: PC_IDLE
  };

  // control store
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = CTL_NOP;
    case (pc)
      PC_IDLE: begin
        w.dispatch = 1'b1;
      end
      PC_RD_OUT: begin
        w.ld = LD_READ;
      end
      PC_RUN_INIT: begin
        w.i_op = CNT_CLR;  w.j_op = CNT_CLR;  w.k_op = CNT_CLR;
        w.cond = COND_N_ZERO;  w.target = PC_DONE;
      end
      PC_DIAG: begin
        w.wr = WR_DIAG;  w.i_op = CNT_STEP;
        w.cond = COND_I_MORE;  w.target = PC_DIAG;
      end
      PC_COPY_RD: begin
        w.rd = RD_COPY;  w.cond = COND_NEVER;
      end
      PC_COPY_WR: begin
        w.piv_wr = 1'b1;  w.i_op = CNT_STEP;
        w.cond = COND_I_MORE;  w.target = PC_COPY_RD;
      end
      PC_RELAX_RD: begin
        w.rd = RD_RELAX;  w.cond = COND_NEVER;
      end
      PC_RELAX_WR: begin
        w.wr = WR_RELAX;  w.j_op = CNT_STEP;  w.i_op = CNT_STEP_ON_J;
        w.cond = COND_IJ_MORE;  w.target = PC_RELAX_RD;
      end
      PC_NEXT_K: begin
        w.k_op = CNT_STEP;
        w.cond = COND_K_MORE;  w.target = PC_COPY_RD;
      end
      PC_DONE: begin
        w.ld = LD_ZERO;
      end
      default: begin
        w = CTL_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/all_pairs_shortest_path.sv =====
// All-pairs shortest path engine: distance matrix, microcoded round sequencer.
//
// Input channel (in_valid/in_stall) carries one beat per operation:
//   op=write : store weight (or "no edge") at row,col. Result on the next cycle.
//   op=run   : force the diagonal of the active nodes to 0, then run the
//              Floyd-Warshall rounds k=0..n-1 (n = node_count, capped at
//              MAX_NODES). Each round copies the pivot row and column, then
//              updates every entry in two steps, read then write, through the
//              single write port of the matrix memory.
//   op=read  : stored distance and reachable, via rd_a and the output register.
//   Other ops and out-of-range indices return a zero beat.
// Every accepted beat yields exactly one output beat (out_valid/out_stall);
// distance/reachable are zero for anything but a read.
// A new input beat is taken only while the sequencer is idle and the output
// register is empty or draining, so writes stream at one beat per cycle when
// the receiver keeps up. A stalled output holds its beat and blocks input.
// node_count is set via cfg_wr_en/cfg_wr_data; the user must do it only while idle,
// not enforced by the block. Reset (rst, synchronous) empties the output, idles
// the sequencer, sets node_count to 16; the matrix is undefined until written.
module all_pairs_shortest_path #(
  parameter int MAX_NODES = apsp_pkg::DEF_MAX_NODES,
  parameter int DIST_BITS = apsp_pkg::DEF_DIST_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            op,
  input  logic [apsp_pkg::IDX_BITS-1:0]         row,
  input  logic [apsp_pkg::IDX_BITS-1:0]         col,
  input  logic signed [apsp_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                                  has_edge,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [apsp_pkg::OUT_BITS-1:0]  distance,
  output logic                                  reachable,
  input  logic                                  cfg_wr_en,
  input  logic [apsp_pkg::CNT_BITS-1:0]         cfg_wr_data
);
  import apsp_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int EW    = DIST_BITS + 1;   // entry: {reach, distance}

  // storage: matrix with two read ports, pivot row/column snapshots
  logic [EW-1:0] mat_mem [DEPTH];
  logic [EW-1:0] prow_mem [MAX_NODES];
  logic [EW-1:0] pcol_mem [MAX_NODES];

  logic [CNT_BITS-1:0] node_count;
  logic [PC_W-1:0]     pc, pc_next;
  logic [IW-1:0]       i_cnt, j_cnt, k_cnt;
  logic [IW-1:0]       i_next, j_next, k_next;
  ctl_t                ctl;

  logic [NW-1:0] n_act;
  logic [IW-1:0] n_last;
  logic          n_zero, i_last, j_last, k_last, cond_hit;

  logic          accept, out_free, in_range;
  logic [AW-1:0] host_addr, addr_a, addr_b, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [EW-1:0] rd_a, rd_b, prow_q, pcol_q;

  logic                        ld_read, ld_zero;
  logic signed [OUT_BITS-1:0]  rd_dist_out;

  function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [31:0] t;
    t = 32'(r) * 32'(MAX_NODES) + 32'(c);
    return t[AW-1:0];
  endfunction

  assign ctl = ucode(pc);

  // active node count, capped
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) n_act = NW'(MAX_NODES);
    else                                  n_act = NW'(node_count);
  end
  assign n_zero = (node_count == '0);
  assign n_last = IW'(n_act - NW'(1));
  assign i_last = (i_cnt == n_last);
  assign j_last = (j_cnt == n_last);
  assign k_last = (k_cnt == n_last);

  always_comb begin
    case (ctl.cond)
      COND_NEVER:   cond_hit = 1'b0;
      COND_ALWAYS:  cond_hit = 1'b1;
      COND_N_ZERO:  cond_hit = n_zero;
      COND_I_MORE:  cond_hit = !i_last;
      COND_IJ_MORE: cond_hit = !(i_last && j_last);
      COND_K_MORE:  cond_hit = !k_last;
      default:      cond_hit = 1'b0;
    endcase
  end

  // input handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(ctl.dispatch && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [31:0] t;
    t         = 32'(row) * 32'(MAX_NODES) + 32'(col);
    host_addr = t[AW-1:0];
    in_range  = (32'(row) < 32'(MAX_NODES)) && (32'(col) < 32'(MAX_NODES));
  end

  // next step
  always_comb begin
    pc_next = cond_hit ? ctl.target : PC_W'(pc + PC_W'(1));
    if (ctl.dispatch) begin
      pc_next = PC_IDLE;
      if (accept && op == OP_RUN) pc_next = PC_RUN_INIT;
      if (accept && op == OP_READ && in_range) pc_next = PC_RD_OUT;
    end
  end

  // loop counters; a step wraps to zero at the last active node
  always_comb begin
    case (ctl.i_op)
      CNT_CLR:       i_next = '0;
      CNT_STEP:      i_next = i_last ? '0 : IW'(i_cnt + IW'(1));
      CNT_STEP_ON_J: i_next = !j_last ? i_cnt : (i_last ? '0 : IW'(i_cnt + IW'(1)));
      default:       i_next = i_cnt;
    endcase
    case (ctl.j_op)
      CNT_CLR:  j_next = '0;
      CNT_STEP: j_next = j_last ? '0 : IW'(j_cnt + IW'(1));
      default:  j_next = j_cnt;
    endcase
    case (ctl.k_op)
      CNT_CLR:  k_next = '0;
      CNT_STEP: k_next = k_last ? '0 : IW'(k_cnt + IW'(1));
      default:  k_next = k_cnt;
    endcase
  end

  // read addresses
  always_comb begin
    case (ctl.rd)
      RD_COPY:  addr_a = mat_addr(k_cnt, i_cnt);
      RD_RELAX: addr_a = mat_addr(i_cnt, j_cnt);
      default:  addr_a = host_addr;
    endcase
    addr_b = mat_addr(i_cnt, k_cnt);
  end

  // relax datapath: saturating sum of the pivot legs, then min
  logic signed [DIST_BITS-1:0] old_d, col_d, row_d, sat_d;
  logic signed [DIST_BITS:0]   sum_w;
  logic                        legs_ok, take;

  always_comb begin
    old_d   = rd_a[DIST_BITS-1:0];
    col_d   = pcol_q[DIST_BITS-1:0];
    row_d   = prow_q[DIST_BITS-1:0];
    legs_ok = pcol_q[DIST_BITS] && prow_q[DIST_BITS];
    sum_w   = (DIST_BITS+1)'(col_d) + (DIST_BITS+1)'(row_d);
    if (sum_w[DIST_BITS] != sum_w[DIST_BITS-1])
      sat_d = {sum_w[DIST_BITS], {(DIST_BITS-1){~sum_w[DIST_BITS]}}};
    else
      sat_d = sum_w[DIST_BITS-1:0];
    take = !rd_a[DIST_BITS] || (sat_d < old_d);
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = host_addr;
    wr_data = {has_edge, has_edge ? DIST_BITS'(weight) : {DIST_BITS{1'b0}}};
    case (ctl.wr)
      WR_DIAG: begin
        wr_en   = 1'b1;
        wr_addr = mat_addr(i_cnt, i_cnt);
        wr_data = {1'b1, {DIST_BITS{1'b0}}};
      end
      WR_RELAX: begin
        wr_en   = legs_ok;
        wr_addr = mat_addr(i_cnt, j_cnt);
        wr_data = {1'b1, take ? sat_d : old_d};
      end
      default: begin
        wr_en = ctl.dispatch && accept && op == OP_WRITE && in_range;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mat_mem[wr_addr] <= wr_data;
    rd_a <= mat_mem[addr_a];
    rd_b <= mat_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (ctl.piv_wr) begin
      prow_mem[i_cnt] <= rd_a;
      pcol_mem[i_cnt] <= rd_b;
    end
    prow_q <= prow_mem[j_cnt];
    pcol_q <= pcol_mem[i_cnt];
  end

  // read result fitted to the output width: clamped if wider, else sign-extended
  generate
    if (DIST_BITS > OUT_BITS) begin : g_clamp
      logic [DIST_BITS-OUT_BITS:0] top;
      always_comb begin
        top = rd_a[DIST_BITS-1:OUT_BITS-1];
        if (&top || ~|top) rd_dist_out = rd_a[OUT_BITS-1:0];
        else rd_dist_out = {rd_a[DIST_BITS-1], {(OUT_BITS-1){~rd_a[DIST_BITS-1]}}};
      end
    end else begin : g_extend
      logic signed [DIST_BITS-1:0] d;
      always_comb begin
        d           = rd_a[DIST_BITS-1:0];
        rd_dist_out = OUT_BITS'(d);
      end
    end
  endgenerate

  // any dispatched beat that does not start a run or an in-range read answers zero
  assign ld_read = (ctl.ld == LD_READ);
  assign ld_zero = (ctl.ld == LD_ZERO) ||
                   (ctl.dispatch && accept && op != OP_RUN && !(op == OP_READ && in_range));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pc         <= PC_IDLE;
      node_count <= NODE_COUNT_RESET;
      i_cnt      <= '0;
      j_cnt      <= '0;
      k_cnt      <= '0;
    end else begin
      pc    <= pc_next;
      i_cnt <= i_next;
      j_cnt <= j_next;
      k_cnt <= k_next;
      if (cfg_wr_en) node_count <= cfg_wr_data;
      if (ld_read || ld_zero) out_valid <= 1'b1;
      else if (!out_stall)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_read) begin
      distance  <= rd_dist_out;
      reachable <= rd_a[DIST_BITS];
    end else if (ld_zero) begin
      distance  <= '0;
      reachable <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/apsp_checker.sv =====
// Port-level checker for the shortest path engine, bound to the top level.
module apsp_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic [1:0]                              op,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [apsp_pkg::OUT_BITS-1:0]    distance,
  input logic                                    reachable
);
  import apsp_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(reachable))
    else $error("stalled output beat changed");

  // no new beat while the output register is blocked
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // a write answers with a zero beat on the next cycle
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    in_beat && op == OP_WRITE |=> out_valid && distance == '0 && !reachable)
    else $error("write did not answer with zero beat");

  // a read occupies the sequencer for its lookup cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && op == OP_READ |=> in_stall)
    else $error("input taken during read lookup");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);

// ===== tb/sv/tb_all_pairs_shortest_path.sv =====
// Testbench for all_pairs_shortest_path: directed and random beats against a shortest-path mirror.
`timescale 1ns / 100ps

module tb_all_pairs_shortest_path;
  import apsp_pkg::*;

  localparam int NODES        = DEF_MAX_NODES;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BEATS = 870;
  localparam int SETTLE       = 4;   // cycles after the last result before a cfg write
  localparam int TAIL         = 20;  // cycles watched for stray beats at the end

  // op 3 has no meaning in the block; it must come back as a zero beat
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [OUT_BITS-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_BITS-1:0] DIST_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] span;
    logic                       reach;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic [IDX_BITS-1:0] row;
  logic [IDX_BITS-1:0] col;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic has_edge;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_BITS-1:0] distance;
  logic reachable;
  logic cfg_wr_en;
  logic [CNT_BITS-1:0] cfg_wr_data;

  // mirror of the distance matrix and the node_count register
  logic signed [OUT_BITS-1:0] mirror_dist [NODES][NODES];
  logic                       mirror_reach [NODES][NODES];
  logic [CNT_BITS-1:0]        mirror_nodes;

  // answers still owed by the block, oldest first
  answer_t due_answers[$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  runs_sent = 0;
  int  reads_sent = 0;
  int  saturated_reads = 0;
  int  cfg_writes = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;  // when set, neither side inserts gaps

  all_pairs_shortest_path uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .row         (row),
    .col         (col),
    .weight      (weight),
    .has_edge    (has_edge),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .distance    (distance),
    .reachable   (reachable),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop; a correct run needs only a fraction of this
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block
  // ---------------------------------------------------------------------------

  // a + b held to the signed 24-bit range
  function automatic logic signed [OUT_BITS-1:0] clamp_sum(
      input logic signed [OUT_BITS-1:0] a, input logic signed [OUT_BITS-1:0] b);
    logic signed [OUT_BITS:0] s;
    s = a + b;
    if (s > $signed({1'b0, DIST_MAX})) return DIST_MAX;
    if (s < $signed({1'b1, DIST_MIN})) return DIST_MIN;
    return s[OUT_BITS-1:0];
  endfunction

  // Diagonal to 0, then rounds k = 0..n-1. Row k and column k are copied
  // before each round, so every round works on the matrix as it was.
  function automatic void relax_all_rounds();
    int n, i, j, k;
    logic signed [OUT_BITS-1:0] prow_d [NODES];
    logic signed [OUT_BITS-1:0] pcol_d [NODES];
    logic prow_r [NODES];
    logic pcol_r [NODES];
    logic signed [OUT_BITS-1:0] s;
    n = (mirror_nodes > NODES) ? NODES : int'(mirror_nodes);
    for (i = 0; i < n; i++) begin
      mirror_dist[i][i] = '0;
      mirror_reach[i][i] = 1'b1;
    end
    for (k = 0; k < n; k++) begin
      for (i = 0; i < n; i++) begin
        prow_d[i] = mirror_dist[k][i];
        prow_r[i] = mirror_reach[k][i];
        pcol_d[i] = mirror_dist[i][k];
        pcol_r[i] = mirror_reach[i][k];
      end
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          if (pcol_r[i] && prow_r[j]) begin
            s = clamp_sum(pcol_d[i], prow_d[j]);
            if (!mirror_reach[i][j] || s < mirror_dist[i][j]) mirror_dist[i][j] = s;
            mirror_reach[i][j] = 1'b1;
          end
        end
      end
    end
  endfunction

  // Apply one accepted beat to the mirror and queue the answer it owes.
  function automatic void mirror_beat(input logic [1:0] b_op,
      input logic [IDX_BITS-1:0] b_row, input logic [IDX_BITS-1:0] b_col,
      input logic signed [WEIGHT_BITS-1:0] b_weight, input logic b_edge);
    answer_t a;
    a = '0;
    case (b_op)
      OP_WRITE: begin
        // a missing edge stores distance 0, unreachable
        mirror_dist[b_row][b_col] = b_edge ? {{(OUT_BITS-WEIGHT_BITS){b_weight[WEIGHT_BITS-1]}},
                                              b_weight} : '0;
        mirror_reach[b_row][b_col] = b_edge;
      end
      OP_RUN: begin
        relax_all_rounds();
        runs_sent++;
      end
      OP_READ: begin
        a.span = mirror_dist[b_row][b_col];
        a.reach = mirror_reach[b_row][b_col];
        reads_sent++;
        if (a.span == DIST_MIN || a.span == DIST_MAX) saturated_reads++;
      end
      default: begin
        a = '0;
      end
    endcase
    due_answers.push_back(a);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // mostly short positive edges, some negative, a few over the full range
  function automatic logic signed [WEIGHT_BITS-1:0] draw_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return WEIGHT_BITS'($urandom_range(0, 200));
    if (r < 92) return -WEIGHT_BITS'($urandom_range(1, 50));
    return WEIGHT_BITS'($urandom);
  endfunction

  // index inside the active block most of the time
  function automatic logic [IDX_BITS-1:0] draw_index(input int active);
    if (active > 0 && $urandom_range(0, 4) != 0) return IDX_BITS'($urandom_range(0, active - 1));
    return IDX_BITS'($urandom_range(0, NODES - 1));
  endfunction

  function automatic int active_nodes();
    return (mirror_nodes > NODES) ? NODES : int'(mirror_nodes);
  endfunction

  // One input beat. Valid stays high into the next beat when no gap is drawn,
  // so this task lowers it only ahead of a gap.
  task automatic send_beat(input logic [1:0] b_op, input logic [IDX_BITS-1:0] b_row,
      input logic [IDX_BITS-1:0] b_col, input logic signed [WEIGHT_BITS-1:0] b_weight,
      input logic b_edge);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= b_op;
    row      <= b_row;
    col      <= b_col;
    weight   <= b_weight;
    has_edge <= b_edge;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror_beat(b_op, b_row, b_col, b_weight, b_edge);
    beats_sent++;
  endtask

  task automatic send_write(input int r, input int c, input logic signed [WEIGHT_BITS-1:0] w,
      input logic e);
    send_beat(OP_WRITE, IDX_BITS'(r), IDX_BITS'(c), w, e);
  endtask

  task automatic send_read(input int r, input int c);
    // weight/has_edge are don't-care here; random keeps them from looking stuck
    send_beat(OP_READ, IDX_BITS'(r), IDX_BITS'(c), WEIGHT_BITS'($urandom), 1'($urandom));
  endtask

  task automatic send_run();
    send_beat(OP_RUN, IDX_BITS'($urandom), IDX_BITS'($urandom), WEIGHT_BITS'($urandom),
              1'($urandom));
  endtask

  // input low, every owed answer back, then a short settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [CNT_BITS-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    mirror_nodes = value;
    cfg_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and output stall
  // ---------------------------------------------------------------------------
  initial begin : answer_checker
    answer_t want;
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (due_answers.size() == 0) begin
          $error("result beat with nothing pending: distance %0d reachable %0b",
                 distance, reachable);
          mismatches++;
        end else begin
          want = due_answers.pop_front();
          if (distance !== want.span) begin
            $error("distance: expected %0d, got %0d", $signed(want.span), distance);
            mismatches++;
          end
          if (reachable !== want.reach) begin
            $error("reachable: expected %0b, got %0b", want.reach, reachable);
            mismatches++;
          end
        end
        // receiver wait before it takes the next beat
        hold = draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every entry gets a value first; no read or run may touch an unwritten one.
  task automatic test_fill_matrix();
    int r, c;
    for (r = 0; r < NODES; r++)
      for (c = 0; c < NODES; c++)
        send_write(r, c, draw_weight(), $urandom_range(0, 3) != 0);
  endtask

  // no cfg write yet, so the run covers all 16 nodes
  task automatic test_reset_node_count();
    send_run();
    send_read(0, 0);
    send_read(15, 3);
  endtask

  // weight extremes, a missing edge with a nonzero weight, corner indices, op 3
  task automatic test_field_extremes();
    send_write(0, 15, 16'sh8000, 1'b1);
    send_write(15, 0, 16'sh7FFF, 1'b1);
    send_write(5, 6, -16'sd1, 1'b1);
    send_write(7, 8, 16'sh5A5A, 1'b0);
    send_read(0, 15);
    send_read(15, 0);
    send_read(5, 6);
    send_read(7, 8);
    send_beat(OP_UNUSED, 4'hF, 4'hF, 16'shFFFF, 1'b1);
  endtask

  // 0 makes a run a no-op, 31 caps at 16, 1 only rewrites the diagonal
  task automatic test_node_count_limits();
    set_node_count(5'd0);
    send_run();
    send_read(2, 3);
    set_node_count(5'd31);
    send_run();
    send_read(9, 4);
    set_node_count(5'd1);
    send_write(0, 0, 16'sd55, 1'b1);
    send_run();
    send_read(0, 0);
  endtask

  // Two-node negative cycle: each run about triples the off-diagonal
  // distances until they pin at the negative limit.
  task automatic test_negative_saturation();
    set_node_count(5'd2);
    send_write(0, 1, 16'sh8000, 1'b1);
    send_write(1, 0, 16'sh8000, 1'b1);
    repeat (6) send_run();
    send_read(0, 0);
    send_read(1, 0);
  endtask

  // Phases: new node_count, a fresh graph when the block is small, mixed
  // traffic, then a run and reads of the result.
  task automatic test_random_phases();
    int sent, pick, n, r, c, len, i;
    logic [CNT_BITS-1:0] count;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) count = '0;
      else if (pick < 9) count = CNT_BITS'($urandom_range(17, 31));
      else if (pick < 20) count = CNT_BITS'($urandom_range(7, 16));
      else count = CNT_BITS'($urandom_range(1, 6));
      set_node_count(count);
      no_idle = ($urandom_range(0, 3) == 0);
      n = active_nodes();
      if (n <= 6) begin
        for (r = 0; r < n; r++)
          for (c = 0; c < n; c++)
            if (r != c) begin
              send_write(r, c, draw_weight(), $urandom_range(0, 3) != 0);
              sent++;
            end
      end
      len = $urandom_range(10, 30);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
          send_write(draw_index(n), draw_index(n), draw_weight(), $urandom_range(0, 3) != 0);
          sent++;
        end else if (pick < 94 && pick >= 88) begin
          send_beat(OP_UNUSED, IDX_BITS'($urandom), IDX_BITS'($urandom),
                    WEIGHT_BITS'($urandom), 1'($urandom));
        end else if (pick >= 94 && n <= 6) begin
          send_run();
          sent++;
        end else begin
          send_read(draw_index(n), draw_index(n));
          sent++;
        end
      end
      send_run();
      sent++;
      for (i = 0; i < ((n == 0) ? 2 : (n > 6 ? 6 : n)); i++) begin
        send_read(draw_index(n), draw_index(n));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_WRITE;
    row         <= '0;
    col         <= '0;
    weight      <= '0;
    has_edge    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    mirror_nodes = NODE_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_matrix();
    test_reset_node_count();
    test_field_extremes();
    test_node_count_limits();
    test_negative_saturation();
    test_random_phases();

    wait_drained();
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d beats: %0d runs, %0d reads (%0d at a saturated distance).",
             beats_sent, runs_sent, reads_sent, saturated_reads);
    $display("node_count written %0d times, from 0 through 31; %0d cycles.",
             cfg_writes, cycles);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
